FILE: rtl/number_literal_scanner_defines.svh
// ----------------------------------------------------------------------------
// Number literal scanner assertion macros
// Shared concurrent assertion forms for the scanner RTL.
// ----------------------------------------------------------------------------
`ifndef NUMBER_LITERAL_SCANNER_DEFINES_SVH
`define NUMBER_LITERAL_SCANNER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define NLS_ASSERT_IMPLY(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define NLS_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`else

`define NLS_ASSERT_IMPLY(name, clk, rst, pre, post, msg)
`define NLS_ASSERT_NEXT(name, clk, rst, pre, post, msg)

`endif

`endif

FILE: rtl/nls_pkg.sv
// ----------------------------------------------------------------------------
// Number literal scanner package
// Word types, scan phases, character codes and byte class helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package nls_pkg;

   // Longest literal length that the byte counter holds.
   localparam int MAX_LEN = 255;
   localparam int CNT_W   = $clog2(MAX_LEN + 1);

   // Character codes used by the scanner.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_4     = 8'h34;
   localparam logic [7:0] CH_6     = 8'h36;
   localparam logic [7:0] CH_7     = 8'h37;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UB    = 8'h42;
   localparam logic [7:0] CH_UD    = 8'h44;
   localparam logic [7:0] CH_UE    = 8'h45;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_UI    = 8'h49;
   localparam logic [7:0] CH_UL    = 8'h4C;
   localparam logic [7:0] CH_UM    = 8'h4D;
   localparam logic [7:0] CH_UP    = 8'h50;
   localparam logic [7:0] CH_UU    = 8'h55;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_USCR  = 8'h5F;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CASE_GAP = 8'h20;

   // Scan phases.
   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_PRE_HEX = 4'd1,
      PH_PRE_BIN = 4'd2,
      PH_DEC     = 4'd3,
      PH_HEX     = 4'd4,
      PH_BIN     = 4'd5,
      PH_OCT     = 4'd6,
      PH_POINT   = 4'd7,
      PH_FRAC    = 4'd8,
      PH_EXPO    = 4'd9,
      PH_ESIGN   = 4'd10,
      PH_EDIG    = 4'd11,
      PH_SUFFIX  = 4'd12,
      PH_SIX     = 4'd13,
      PH_FOUR    = 4'd14,
      PH_JUNK    = 4'd15
   } phase_type;

   // Input word.
   typedef struct packed {
      logic [7:0] ch;
      logic [7:0] next_ch;
      logic       start_req;
   } req_type;

   // Result word.
   typedef struct packed {
      logic       recognized;
      logic [7:0] literal_length;
      logic       float_flag;
   } rsp_type;

   // Everything one scan step decides.
   typedef struct packed {
      logic             emit;
      rsp_type          rsp;
      phase_type        phase;
      logic [CNT_W-1:0] count;
      logic             float_seen;
      logic             hex_seen;
   } step_type;

   // ASCII upper-case fold.
   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= CH_LA && c <= CH_LZ) ? c - CASE_GAP : c;
   endfunction

   function automatic logic is_dig(input logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   function automatic logic is_xdig(input logic [7:0] c);
      logic [7:0] u;
      u = to_upper(c);
      return is_dig(c) || (u >= CH_UA && u <= CH_UF);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      logic [7:0] u;
      u = to_upper(c);
      return is_dig(c) || (u >= CH_UA && u <= CH_UZ);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/number_literal_scanner.sv
// ----------------------------------------------------------------------------
// Number literal scanner
// Measures C-family numeric literals in a byte stream, one byte per clock while rsp_ready allows.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one text byte per word, its lookahead byte and a
// start flag marking the first byte of a token attempt. The rsp channel
// carries at most one result per input word: recognized, the literal length
// (saturated) and a float flag. A literal is reported on the word holding
// the first byte past it; a start byte that cannot open a literal is
// answered at once with recognized low when no scan is in progress.
// Each word is held in the input register and its result is then loaded
// into the result register, which drives rsp_valid and rsp_data.
// Throughput: one word per clock unless rsp_ready stalls the result register;
// each step is one pass through the phase decision between the two registers.
// Reset: synchronous and active high; clears both registers' valid flags
// and returns the scanner to idle with a zero count.
// Stall: while rsp_ready is low, the result register holds its word, the
// word in the input register waits, and req_ready falls once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "number_literal_scanner_defines.svh"

module number_literal_scanner (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nls_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nls_pkg::rsp_type rsp_data
);

   logic                          in_vld_ff, in_vld_in;
   nls_pkg::req_type              in_word_ff;
   logic                          out_vld_ff, out_vld_in;
   nls_pkg::rsp_type              out_word_ff;
   nls_pkg::phase_type            phase_ff, phase_in;
   logic [nls_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                          float_ff, float_in;
   logic                          hex_ff, hex_in;
   nls_pkg::step_type             step;
   logic                          advance;

   // Phase decision for the word in the input register.
   nls_step u_step (
      .phase      (phase_ff),
      .count      (count_ff),
      .float_seen (float_ff),
      .hex_seen   (hex_ff),
      .word       (in_word_ff),
      .step       (step)
   );

   // The held word moves on when the result register is free or draining.
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_word_ff;

   // Next values of the control and scan state.
   always_comb begin
      in_vld_in  = req_ready ? req_valid : in_vld_ff;
      out_vld_in = out_vld_ff && !rsp_ready;
      phase_in   = phase_ff;
      count_in   = count_ff;
      float_in   = float_ff;
      hex_in     = hex_ff;
      if (advance) begin
         out_vld_in = step.emit || (out_vld_ff && !rsp_ready);
         phase_in   = step.phase;
         count_in   = step.count;
         float_in   = step.float_seen;
         hex_in     = step.hex_seen;
      end
   end

   // Control and scan state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         phase_ff   <= nls_pkg::PH_IDLE;
         count_ff   <= '0;
         float_ff   <= 1'b0;
         hex_ff     <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         float_ff   <= float_in;
         hex_ff     <= hex_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
      if (advance && step.emit) begin
         out_word_ff <= step.rsp;
      end
   end

   // A rejected attempt carries no length and no float flag.
   `NLS_ASSERT_IMPLY(a_reject_empty, clock, reset,
      rsp_valid && !rsp_data.recognized,
      rsp_data.literal_length == 8'd0 && !rsp_data.float_flag,
      "rejected result has nonzero fields")

   // Idle scanner holds no count and no flags.
   `NLS_ASSERT_IMPLY(a_idle_clear, clock, reset, phase_ff == nls_pkg::PH_IDLE,
      count_ff == '0 && !float_ff && !hex_ff, "idle scanner state not cleared")

   // Any active scan has counted at least its start byte.
   `NLS_ASSERT_IMPLY(a_scan_count, clock, reset, phase_ff != nls_pkg::PH_IDLE,
      count_ff != '0, "active scan with zero count")

   // A hex prefix never leads into a decimal, octal or binary body.
   `NLS_ASSERT_IMPLY(a_hex_body, clock, reset, hex_ff,
      phase_ff != nls_pkg::PH_DEC && phase_ff != nls_pkg::PH_OCT &&
      phase_ff != nls_pkg::PH_BIN && phase_ff != nls_pkg::PH_PRE_BIN,
      "hex flag set in a non-hex body")

   // A stalled result is never replaced by a new one.
   `NLS_ASSERT_NEXT(a_hold_result, clock, reset, out_vld_ff && !rsp_ready,
      out_vld_ff && $stable(out_word_ff), "stalled result overwritten")

endmodule

`default_nettype wire

FILE: rtl/nls_step.sv
// ----------------------------------------------------------------------------
// Number literal scanner step logic
// Decides, for one byte, whether it extends the literal and what comes next.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_step (
   input  nls_pkg::phase_type               phase,
   input  logic [nls_pkg::CNT_W-1:0]        count,
   input  logic                             float_seen,
   input  logic                             hex_seen,
   input  nls_pkg::req_type                 word,
   output nls_pkg::step_type                step
);

   logic [7:0] ch;
   logic [7:0] nx;
   logic [7:0] u;
   logic       is_us;
   logic       in_body;
   logic       body_acc;
   logic       at_point, acc_point;
   logic       acc_frac;
   logic       at_expo, acc_expo;
   logic       acc_esign;
   logic       at_edig, acc_edig;
   logic       at_suffix, acc_suffix, float_suffix;
   logic       at_six, acc_six;
   logic       at_junk, acc_junk;
   logic       taken;
   logic       start_ok;
   logic [7:0] clip_len;

   assign ch    = word.ch;
   assign nx    = word.next_ch;
   assign u     = nls_pkg::to_upper(ch);
   assign is_us = (ch == nls_pkg::CH_USCR);

   // Digit run acceptance for the four literal bodies.
   always_comb begin
      unique case (phase)
         nls_pkg::PH_DEC: body_acc = nls_pkg::is_dig(ch) || is_us;
         nls_pkg::PH_HEX: body_acc = nls_pkg::is_xdig(ch) || is_us;
         nls_pkg::PH_BIN: body_acc = ch == nls_pkg::CH_0 || ch == nls_pkg::CH_1 || is_us;
         nls_pkg::PH_OCT: body_acc = (ch >= nls_pkg::CH_0 && ch <= nls_pkg::CH_7) || is_us;
         default:         body_acc = 1'b0;
      endcase
   end

   assign in_body = phase == nls_pkg::PH_DEC || phase == nls_pkg::PH_HEX ||
                    phase == nls_pkg::PH_BIN || phase == nls_pkg::PH_OCT;

   // Phases that pass a byte on fall through to the next one within the step.
   assign at_point  = phase == nls_pkg::PH_POINT || (in_body && !body_acc);
   assign acc_point = at_point && ch == nls_pkg::CH_DOT && nx != nls_pkg::CH_DOT;

   assign acc_frac  = phase == nls_pkg::PH_FRAC &&
                      ((hex_seen ? nls_pkg::is_xdig(ch) : nls_pkg::is_dig(ch)) || is_us);

   assign at_expo   = (at_point && !acc_point) || (phase == nls_pkg::PH_FRAC && !acc_frac) ||
                      phase == nls_pkg::PH_EXPO;
   assign acc_expo  = at_expo && (u == nls_pkg::CH_UE || u == nls_pkg::CH_UP);

   assign acc_esign = phase == nls_pkg::PH_ESIGN &&
                      (ch == nls_pkg::CH_PLUS || ch == nls_pkg::CH_MINUS);
   assign at_edig   = (phase == nls_pkg::PH_ESIGN && !acc_esign) || phase == nls_pkg::PH_EDIG;
   assign acc_edig  = at_edig && (nls_pkg::is_dig(ch) || is_us);

   assign at_suffix    = (at_expo && !acc_expo) || (at_edig && !acc_edig) ||
                         phase == nls_pkg::PH_SUFFIX;
   assign float_suffix = u == nls_pkg::CH_UI || u == nls_pkg::CH_UF ||
                         u == nls_pkg::CH_UD || u == nls_pkg::CH_UM;
   assign acc_suffix   = at_suffix &&
                         (float_suffix || u == nls_pkg::CH_UL || u == nls_pkg::CH_UU);

   assign at_six   = (at_suffix && !acc_suffix) || phase == nls_pkg::PH_SIX;
   assign acc_six  = at_six && ch == nls_pkg::CH_6 && nx == nls_pkg::CH_4;

   assign at_junk  = (at_six && !acc_six) || phase == nls_pkg::PH_JUNK;
   assign acc_junk = at_junk && nls_pkg::is_alnum(ch);

   assign taken = phase == nls_pkg::PH_PRE_HEX || phase == nls_pkg::PH_PRE_BIN ||
                  phase == nls_pkg::PH_FOUR || body_acc || acc_point || acc_frac ||
                  acc_expo || acc_esign || acc_edig || acc_suffix || acc_six || acc_junk;

   // A literal may open with a digit, or with a dot that a digit follows.
   assign start_ok = nls_pkg::is_dig(ch) || (ch == nls_pkg::CH_DOT && nls_pkg::is_dig(nx));

   // Reported length is the counter clipped to the field width.
   assign clip_len = (32'(count) > 32'd255) ? 8'hFF : 8'(count);

   // Step decision and next state.
   always_comb begin
      step                    = '0;
      step.phase              = phase;
      step.count              = count;
      step.float_seen         = float_seen;
      step.hex_seen           = hex_seen;
      step.rsp.recognized     = 1'b1;
      step.rsp.literal_length = clip_len;
      step.rsp.float_flag     = float_seen;

      if (word.start_req) begin
         // A start closes any scan in progress and opens a new attempt.
         step.emit       = phase != nls_pkg::PH_IDLE;
         step.phase      = nls_pkg::PH_IDLE;
         step.count      = '0;
         step.float_seen = 1'b0;
         step.hex_seen   = 1'b0;
         if (!start_ok) begin
            if (phase == nls_pkg::PH_IDLE) begin
               step.emit = 1'b1;
               step.rsp  = '0;
            end
         end else begin
            step.count      = nls_pkg::CNT_W'(1);
            step.float_seen = ch == nls_pkg::CH_DOT;
            if (ch == nls_pkg::CH_0) begin
               if (nls_pkg::to_upper(nx) == nls_pkg::CH_UX) begin
                  step.hex_seen = 1'b1;
                  step.phase    = nls_pkg::PH_PRE_HEX;
               end else if (nls_pkg::to_upper(nx) == nls_pkg::CH_UB) begin
                  step.phase = nls_pkg::PH_PRE_BIN;
               end else if (nx >= nls_pkg::CH_0 && nx <= nls_pkg::CH_7) begin
                  step.phase = nls_pkg::PH_OCT;
               end else begin
                  step.phase = nls_pkg::PH_POINT;
               end
            end else begin
               step.phase = nls_pkg::PH_DEC;
            end
         end
      end else if (phase != nls_pkg::PH_IDLE) begin
         if (taken) begin
            // Byte extends the literal: count it and move on.
            if (32'(count) < nls_pkg::MAX_LEN) begin
               step.count = count + nls_pkg::CNT_W'(1);
            end
            step.float_seen = float_seen || acc_point || acc_expo ||
                              (acc_suffix && float_suffix);
            if (phase == nls_pkg::PH_PRE_HEX) begin
               step.phase = nls_pkg::PH_HEX;
            end else if (phase == nls_pkg::PH_PRE_BIN) begin
               step.phase = nls_pkg::PH_BIN;
            end else if (body_acc) begin
               step.phase = phase;
            end else if (acc_point || acc_frac) begin
               step.phase = nls_pkg::PH_FRAC;
            end else if (acc_expo) begin
               step.phase = nls_pkg::PH_ESIGN;
            end else if (acc_esign || acc_edig) begin
               step.phase = nls_pkg::PH_EDIG;
            end else if (acc_suffix) begin
               step.phase = nls_pkg::PH_SUFFIX;
            end else if (acc_six) begin
               step.phase = nls_pkg::PH_FOUR;
            end else begin
               step.phase = nls_pkg::PH_JUNK;
            end
         end else begin
            // First byte outside the literal: report and go idle.
            step.emit       = 1'b1;
            step.phase      = nls_pkg::PH_IDLE;
            step.count      = '0;
            step.float_seen = 1'b0;
            step.hex_seen   = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire
